// ----- sv/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions for the LRU key-value cache
// Command codes, config width and the per-cycle update control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int CFG_BITS = 5;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Control broadcast from the sequencer to every cell during the update cycle.
  typedef struct packed {
    logic go;     // apply the update at this edge
    logic put;    // operation is a put
    logic hit;    // key was present
    logic evict;  // cache full: a put miss replaces the oldest entry
  } upd_t;

endpackage

`default_nettype wire

// ----- sv/lkvc_req_if.sv -----
// ----------------------------------------------------------------------------
// lkvc_req_if: request channel of the LRU key-value cache
// Valid/ready channel carrying one get or put beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if #(
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, cmd, lookup_key, write_value, input ready);
  modport sink   (input valid, cmd, lookup_key, write_value, output ready);
endinterface

`default_nettype wire

// ----- sv/lkvc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lkvc_rsp_if: response channel of the LRU key-value cache
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_rsp_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;

  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

`default_nettype wire

// ----- sv/lkvc_cell.sv -----
// ----------------------------------------------------------------------------
// lkvc_cell: one entry slot of the LRU key-value cache
// Holds key, value, valid and recency rank; compares against the broadcast
// key and merges its hit into the lookup chain passed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32,
  parameter int IW         = 4,
  parameter int IDX        = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [KEY_BITS-1:0]    key_i,
  input  wire [VALUE_BITS-1:0]  value_i,
  input  wire                   cap_i,        // latch match flag (match cycle)
  input  wire lkvc_pkg::upd_t   upd_i,
  input  wire [IW-1:0]          hit_rank_i,
  input  wire [IW-1:0]          victim_rank_i,
  input  wire [IW-1:0]          ins_idx_i,
  input  wire                   chn_hit_i,
  input  wire [IW-1:0]          chn_rank_i,
  input  wire [VALUE_BITS-1:0]  chn_value_i,
  output logic                  chn_hit_o,
  output logic [IW-1:0]         chn_rank_o,
  output logic [VALUE_BITS-1:0] chn_value_o,
  output logic                  valid_o,
  output logic                  match_o
);
  import lkvc_pkg::*;

  localparam logic [IW-1:0] RANK_MAX = IW'(ENTRIES - 1);
  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  valid_r, valid_nxt;
  logic [IW-1:0]         rank_r, rank_nxt;
  logic                  match_r;
  logic                  match;
  logic                  target;
  logic                  load_kv;
  logic                  load_v;

  assign match = valid_r && (key_r == key_i);

  assign chn_hit_o   = chn_hit_i | match;
  assign chn_rank_o  = chn_rank_i | (match ? rank_r : '0);
  assign chn_value_o = chn_value_i | (match ? value_r : '0);
  assign valid_o     = valid_r;
  assign match_o     = match_r;

  // Slot this operation lands on
  always_comb begin
    if (upd_i.hit)        target = match_r;
    else if (upd_i.evict) target = valid_r && (rank_r == victim_rank_i);
    else                  target = (MY_IDX == ins_idx_i);
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    load_kv   = 1'b0;
    load_v    = 1'b0;
    if (upd_i.go) begin
      if (upd_i.hit) begin
        if (target) begin
          rank_nxt = '0;
          load_v   = upd_i.put;
        end else if (valid_r && rank_r < hit_rank_i) begin
          rank_nxt = rank_r + 1'b1;
        end
      end else if (upd_i.put) begin
        if (target) begin
          valid_nxt = 1'b1;
          rank_nxt  = '0;
          load_kv   = 1'b1;
        end else if (valid_r && rank_r < RANK_MAX) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      if (cap_i) match_r <= match;
    end
  end

  always_ff @(posedge clk) begin
    if (load_kv) key_r <= key_i;
    if (load_kv || load_v) value_r <= value_i;
  end

endmodule

`default_nettype wire

// ----- sv/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Row of entry cells with a small sequencer for lookup and update.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request beats {cmd, lookup_key, write_value}; cmd get or put.
//   out_ch : one result beat per request {hit, read_value, evicted}, in order.
//   cfg_we/cfg_data : capacity in use; taken only while the cache is empty,
//            0 saturates to 1 and values above ENTRIES saturate to ENTRIES.
// Timing:
//   A request beat is taken, the match cycle runs the key through the cell
//   chain, and the update cycle rewrites ranks and loads the result register.
//   A new request is taken in the update cycle, as the previous one completes,
//   so the match/update pair over the cell row sets the sustained rate.
// Reset:
//   All entries invalid, ranks zero, occupancy zero, capacity = ENTRIES.
// Back-pressure:
//   The result register holds one beat; while it is full and out_ch.ready is
//   low the update cycle waits, and in_ch.ready stays low until it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  lkvc_req_if.sink                     in_ch,
  lkvc_rsp_if.source                   out_ch,
  input  wire                          cfg_we,
  input  wire [lkvc_pkg::CFG_BITS-1:0] cfg_data
);
  import lkvc_pkg::*;

  // Rank / slot index width and occupancy counter width
  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CFG_BITS) ? CW : CFG_BITS;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]            st_r, st_nxt;

  // Latched request
  logic                  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] wval_r;

  // Lookup result captured at the end of the match cycle
  logic                  hit_r;
  logic [IW-1:0]         hit_rank_r;
  logic [VALUE_BITS-1:0] rd_r;

  logic [CW-1:0]         occ_r, occ_nxt;
  logic [CW-1:0]         cap_r, cap_nxt;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_evicted_r;

  logic                  in_fire;
  logic                  upd_go;
  logic                  evict;
  upd_t                  upd;
  logic [CW-1:0]         occ_dec;
  logic [IW-1:0]         victim_rank;
  logic [IW-1:0]         ins_idx;
  logic [CMPW-1:0]       cfg_ext;

  // Lookup chain between cells
  logic                  chn_hit   [ENTRIES+1];
  logic [IW-1:0]         chn_rank  [ENTRIES+1];
  logic [VALUE_BITS-1:0] chn_value [ENTRIES+1];
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    match_vec;

  // ---------------------------------------------------------------- control
  // Update waits while the result register is full and not drained.
  assign upd_go  = (st_r == ST_UPDATE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (st_r == ST_IDLE) || upd_go;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Full cache: a put miss replaces the oldest entry. Valid ranks are dense
  // 0..occ-1, so the oldest has rank occ-1; valid slots are 0..occ-1, so the
  // first free slot is index occ.
  assign evict       = (occ_r >= cap_r);
  assign occ_dec     = occ_r - CW'(1);
  assign victim_rank = occ_dec[IW-1:0];
  assign ins_idx     = occ_r[IW-1:0];

  assign upd.go    = upd_go;
  assign upd.put   = (cmd_r == CMD_PUT);
  assign upd.hit   = hit_r;
  assign upd.evict = evict;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_fire) st_nxt = ST_MATCH;
      ST_MATCH:  st_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (upd_go) st_nxt = in_fire ? ST_MATCH : ST_IDLE;
      end
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (upd_go && cmd_r == CMD_PUT && !hit_r && !evict) occ_nxt = occ_r + CW'(1);
  end

  // Capacity write with saturation, only while empty
  assign cfg_ext = CMPW'(cfg_data);
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we && occ_r == '0) begin
      if (cfg_ext == '0)                    cap_nxt = CW'(1);
      else if (cfg_ext > CMPW'(ENTRIES))    cap_nxt = CW'(ENTRIES);
      else                                  cap_nxt = cfg_ext[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      occ_r       <= '0;
      cap_r       <= CW'(ENTRIES);
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      occ_r <= occ_nxt;
      cap_r <= cap_nxt;
      if (upd_go)            out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (st_r == ST_MATCH)  hit_r <= chn_hit[ENTRIES];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_ch.cmd;
      key_r  <= in_ch.lookup_key;
      wval_r <= in_ch.write_value;
    end
    if (st_r == ST_MATCH) begin
      hit_rank_r <= chn_rank[ENTRIES];
      rd_r       <= chn_value[ENTRIES];
    end
    if (upd_go) begin
      out_hit_r     <= hit_r;
      out_value_r   <= (cmd_r == CMD_GET && hit_r) ? rd_r : '0;
      out_evicted_r <= (cmd_r == CMD_PUT) && !hit_r && evict;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.evicted    = out_evicted_r;

  // ------------------------------------------------------------------ cells
  assign chn_hit[0]   = 1'b0;
  assign chn_rank[0]  = '0;
  assign chn_value[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IW         (IW),
      .IDX        (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .key_i         (key_r),
      .value_i       (wval_r),
      .cap_i         (st_r == ST_MATCH),
      .upd_i         (upd),
      .hit_rank_i    (hit_rank_r),
      .victim_rank_i (victim_rank),
      .ins_idx_i     (ins_idx),
      .chn_hit_i     (chn_hit[g]),
      .chn_rank_i    (chn_rank[g]),
      .chn_value_i   (chn_value[g]),
      .chn_hit_o     (chn_hit[g+1]),
      .chn_rank_o    (chn_rank[g+1]),
      .chn_value_o   (chn_value[g+1]),
      .valid_o       (valid_vec[g]),
      .match_o       (match_vec[g])
    );
  end

  // ------------------------------------------------------------- assertions
  // Occupancy never exceeds the configured capacity.
  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cap_r)
    else $error("occupancy above capacity");

  // Valid bits track the occupancy counter.
  a_occ_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("valid bits disagree with occupancy");

  // Keys are unique: at most one cell matches.
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("multiple cells matched one key");

  // A completed update always presents a result beat.
  a_upd_out: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_valid_r)
    else $error("update completed without a result beat");

endmodule

`default_nettype wire
